// ===== design/cdi_pkg.sv =====
// Package for the complex double to int32 checker.
// Holds field widths and constants shared by the core and its conversion pipeline.
package cdi_pkg;
   localparam int unsigned DBL_W   = 64;
   localparam int unsigned INT_W   = 32;
   localparam int unsigned EXP_W   = 11;
   localparam int unsigned MANT_W  = 52;
   localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [EXP_W-1:0] EXP_BIAS     = 11'd1023;
   localparam logic [EXP_W-1:0] EXP_MAX_OK   = 11'd1053; // bias + 30
   localparam logic [INT_W-1:0] SENTINEL     = 32'h8000_0000;

   typedef struct packed {
      logic       nan_any;
      logic       imag_nz;
      logic       real_zero;
      logic       real_bad;
      logic       sign;
   } cls_type;
endpackage

// ===== design/cdi_convert.sv =====
// Three-stage pipeline: classify, shift and check fraction, negate and pick result.
// Depends on cdi_pkg.
module cdi_convert (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [cdi_pkg::DBL_W-1:0]   real_bits,
   input  logic [cdi_pkg::DBL_W-1:0]   imag_bits,
   output logic                        out_valid,
   output logic [cdi_pkg::INT_W-1:0]   int_value,
   output logic                        not_real,
   output logic                        inexact
);
   // Stage 1: classify both parts and compute the right shift amount.
   cdi_pkg::cls_type             s1_cls_ff, s1_cls_in;
   logic [cdi_pkg::MANT_W:0]     s1_sig_ff, s1_sig_in;
   logic [5:0]                   s1_sh_ff, s1_sh_in;
   logic                         s1_v_ff;
   logic [cdi_pkg::EXP_W-1:0]    re_e, im_e;
   logic [5:0]                   ue;

   always_comb begin
      re_e = real_bits[62:52];
      im_e = imag_bits[62:52];
      ue   = 6'(re_e - cdi_pkg::EXP_BIAS);
      s1_cls_in.nan_any = (re_e == cdi_pkg::EXP_ALL_ONES && real_bits[51:0] != '0) ||
                          (im_e == cdi_pkg::EXP_ALL_ONES && imag_bits[51:0] != '0);
      s1_cls_in.imag_nz   = imag_bits[62:0] != '0;
      s1_cls_in.real_zero = real_bits[62:0] == '0;
      s1_cls_in.real_bad  = re_e < cdi_pkg::EXP_BIAS || re_e > cdi_pkg::EXP_MAX_OK;
      s1_cls_in.sign      = real_bits[63];
      s1_sig_in = {1'b1, real_bits[51:0]};
      s1_sh_in  = 6'd52 - ue;
   end

   // Stage 2: shift down and check that no fraction bits were lost.
   cdi_pkg::cls_type             s2_cls_ff;
   logic [30:0]                  s2_mag_ff, s2_mag_in;
   logic                         s2_frac_ff, s2_frac_in;
   logic                         s2_v_ff;
   logic [cdi_pkg::MANT_W:0]     low_mask;

   always_comb begin
      low_mask   = ~({(cdi_pkg::MANT_W+1){1'b1}} << s1_sh_ff);
      s2_frac_in = (s1_sig_ff & low_mask) != '0;
      s2_mag_in  = 31'(s1_sig_ff >> s1_sh_ff);
   end

   // Stage 3: apply sign and choose the final result.
   logic [cdi_pkg::INT_W-1:0]    s3_val_ff, s3_val_in;
   logic                         s3_nn_ff, s3_nn_in, s3_bad_ff, s3_bad_in, s3_v_ff;
   logic [cdi_pkg::INT_W-1:0]    signed_mag;

   always_comb begin
      signed_mag = s2_cls_ff.sign ? (32'd0 - {1'b0, s2_mag_ff}) : {1'b0, s2_mag_ff};
      s3_val_in  = cdi_pkg::SENTINEL;
      s3_nn_in   = 1'b0;
      s3_bad_in  = 1'b0;
      priority if (s2_cls_ff.nan_any) begin
         s3_val_in = cdi_pkg::SENTINEL;
      end else if (s2_cls_ff.imag_nz) begin
         s3_nn_in = 1'b1;
      end else if (s2_cls_ff.real_zero) begin
         s3_val_in = '0;
      end else if (s2_cls_ff.real_bad || s2_frac_ff) begin
         s3_bad_in = 1'b1;
      end else begin
         s3_val_in = signed_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cls_ff  <= s1_cls_in;
         s1_sig_ff  <= s1_sig_in;
         s1_sh_ff   <= s1_sh_in;
         s2_cls_ff  <= s1_cls_ff;
         s2_mag_ff  <= s2_mag_in;
         s2_frac_ff <= s2_frac_in;
         s3_val_ff  <= s3_val_in;
         s3_nn_ff   <= s3_nn_in;
         s3_bad_ff  <= s3_bad_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign int_value = s3_val_ff;
   assign not_real  = s3_nn_ff;
   assign inexact   = s3_bad_ff;
endmodule

// ===== design/complex_double_to_int32_checker_core.sv =====
// Top level of the complex double to int32 checker.
// Depends on cdi_pkg and cdi_convert.
//
// Each request beat carries one complex value as two raw binary64 patterns and yields
// exactly one response beat. If either part is NaN the response is -2147483648 with both
// flags clear; a nonzero or infinite imaginary part (negative zero counts as zero) sets
// not_real; otherwise a real part that is not a finite whole number in
// -2147483647..2147483647 sets inexact, and the exact integer is returned if it is.
// convertible is the NOR of the two flags. The block accepts one beat per cycle
// while not stalled and passes it through a three-stage pipeline (classify, shift with
// fraction check, sign and select). The whole pipeline advances when the response
// register is empty or being taken, so backpressure stalls it without losing any beat.
module complex_double_to_int32_checker_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cdi_pkg::DBL_W-1:0]         req_real_bits,
   input  logic [cdi_pkg::DBL_W-1:0]         req_imag_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cdi_pkg::INT_W-1:0]  rsp_int_value,
   output logic                              rsp_not_real,
   output logic                              rsp_inexact,
   output logic                              rsp_convertible
);
   logic                       advance;
   logic                       pipe_valid;
   logic [cdi_pkg::INT_W-1:0]  pipe_value;
   logic                       pipe_nn;
   logic                       pipe_bad;

   // The last stage is the output register; it moves when empty or drained.
   assign advance   = !pipe_valid || rsp_ready;
   assign req_ready = advance;

   cdi_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .real_bits (req_real_bits),
      .imag_bits (req_imag_bits),
      .out_valid (pipe_valid),
      .int_value (pipe_value),
      .not_real  (pipe_nn),
      .inexact   (pipe_bad)
   );

   assign rsp_valid       = pipe_valid;
   assign rsp_int_value   = signed'(pipe_value);
   assign rsp_not_real    = pipe_nn;
   assign rsp_inexact     = pipe_bad;
   assign rsp_convertible = !(pipe_nn || pipe_bad);

   // The two flags never both appear on one beat.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_not_real && rsp_inexact))
      else $error("both flags set");

   // Any flagged beat carries the sentinel value.
   a_flag_sentinel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_convertible) |-> (pipe_value == cdi_pkg::SENTINEL))
      else $error("flagged beat without sentinel");

   // A stalled response holds while the pipeline is frozen.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pipe_value)))
      else $error("response changed under stall");
endmodule
